### rtl/sapa_pkg.sv
// sapa_pkg: shared widths, state encoding, register indexes and saturation helpers
// for the smoothed all-pass phase aligner; no dependencies
package sapa_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int HIST_BITS = SAMPLE_BITS + 2;
  localparam int DELAY_INT_BITS = 10;
  localparam int DELAY_FRAC_BITS = 20;
  localparam int DELAY_BITS = DELAY_INT_BITS + DELAY_FRAC_BITS;
  localparam int SMOOTH_BITS = 24;
  localparam int COEF_FRAC = 24;
  localparam int IDENTITY_DELAY = 105;
  localparam int SMOOTH_RESET = 17466;

  // serial multiplier: wide signed operand times unsigned magnitude
  localparam int MUL_A_W = DELAY_BITS + 2;
  localparam int MUL_B_W = COEF_FRAC + 1;
  localparam int PROD_W = MUL_A_W + MUL_B_W + 1;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // restoring divider
  localparam int DIVS_W = DELAY_BITS + 1;
  localparam int DIVD_W = DIVS_W + COEF_FRAC;
  localparam int Q_W = COEF_FRAC + 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  localparam int ROUND_W = PROD_W - COEF_FRAC;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_LOW_TARGET = 2'd0,
    REG_MID_TARGET = 2'd1,
    REG_SMOOTH     = 2'd2,
    REG_NONE       = 2'd3
  } sapa_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_SECT,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } sapa_state_t;

  function automatic logic signed [HIST_BITS-1:0] sat_hist(
    input logic signed [ROUND_W-1:0] v);
    logic signed [ROUND_W-1:0] hi;
    logic signed [ROUND_W-1:0] lo;
    hi = ROUND_W'((64'sd1 <<< (HIST_BITS - 1)) - 1);
    lo = -hi - ROUND_W'(1);
    if (v > hi) return HIST_BITS'(hi);
    else if (v < lo) return HIST_BITS'(lo);
    else return HIST_BITS'(v);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [HIST_BITS-1:0] v);
    logic signed [HIST_BITS-1:0] hi;
    logic signed [HIST_BITS-1:0] lo;
    hi = HIST_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    lo = -hi - HIST_BITS'(1);
    if (v > hi) return SAMPLE_BITS'(hi);
    else if (v < lo) return SAMPLE_BITS'(lo);
    else return SAMPLE_BITS'(v);
  endfunction

endpackage

### rtl/sapa_if.sv
// sapa_if: valid/ready channels for input requests and results
// depends on sapa_pkg for field widths
interface sapa_in_if;
  logic valid;
  logic ready;
  logic signed [sapa_pkg::SAMPLE_BITS-1:0] sample_in;
  logic block_start;
  modport source (output valid, sample_in, block_start, input ready);
  modport sink (input valid, sample_in, block_start, output ready);
endinterface

interface sapa_out_if;
  logic valid;
  logic ready;
  logic signed [sapa_pkg::SAMPLE_BITS-1:0] sample_out;
  logic aligner_active;
  modport source (output valid, sample_out, aligner_active, input ready);
  modport sink (input valid, sample_out, aligner_active, output ready);
endinterface

### rtl/sapa_mul.sv
// sapa_mul: shift-add multiplier, one multiplier bit per cycle
// depends on sapa_pkg
module sapa_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [sapa_pkg::MUL_A_W-1:0]   a,
  input  logic        [sapa_pkg::MUL_B_W-1:0]   b,
  input  logic                                  neg,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [sapa_pkg::PROD_W-1:0]    prod
);
  import sapa_pkg::*;

  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic signed [PROD_W-1:0] a_r, a_nxt;
  logic [MUL_B_W-1:0] b_r, b_nxt;
  logic neg_r, neg_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      a_nxt = PROD_W'(a);
      b_nxt = b;
      neg_nxt = neg;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r <<< 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r + MUL_CNT_W'(1);
      if (cnt_r == MUL_CNT_W'(MUL_B_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = neg_r ? -acc_r : acc_r;

endmodule

### rtl/sapa_div.sv
// sapa_div: restoring divider, one quotient bit per cycle
// depends on sapa_pkg
module sapa_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [sapa_pkg::DIVD_W-1:0]      dividend,
  input  logic [sapa_pkg::DIVS_W-1:0]      divisor,
  output logic                             busy,
  output logic                             done,
  output logic [sapa_pkg::Q_W-1:0]         quot
);
  import sapa_pkg::*;

  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] dvd_r, dvd_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [Q_W-1:0] q_r, q_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [DIVS_W:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, dvd_r[DIVD_W-1]};
    if (start) begin
      rem_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
      q_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIVS_W'(trial - {1'b0, dvs_r});
        q_nxt = {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIVS_W'(trial);
        q_nxt = {q_r[Q_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    q_r <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

### rtl/smoothed_allpass_phase_aligner.sv
// smoothed_allpass_phase_aligner: two cascaded first-order all-pass sections with
// smoothed delays; depends on sapa_pkg, sapa_if, sapa_mul, sapa_div
//
//   channel   dir   handshake                 payload
//   in_ch     in    valid/ready               sample_in, block_start
//   out_ch    out   valid/ready               sample_out, aligner_active
//   cfg_*     in    apb write, pready high    low/mid target delay, smooth weight
//
// one request at a time; a bypassed request goes from accept straight to the done
// state, a processed one first smooths both delays (two serial multiplies), then
// runs a serial divide and a serial multiply per active section; the serial divide,
// one quotient bit per cycle, is the longest step
// rst_n is synchronous; it clears the delays, histories, bypass flag and target registers
// a new request is taken as soon as the sequencer is idle, even while the last
// result still waits in the output register for out_ch.ready
module smoothed_allpass_phase_aligner (
  input  logic                                   clk,
  input  logic                                   rst_n,
  sapa_in_if.sink                                in_ch,
  sapa_out_if.source                             out_ch,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [sapa_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [sapa_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [sapa_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);
  import sapa_pkg::*;

  // configuration registers
  logic [DELAY_BITS-1:0] low_target_r;
  logic [DELAY_BITS-1:0] mid_target_r;
  logic [SMOOTH_BITS-1:0] smooth_r;
  sapa_reg_t cfg_reg;
  logic cfg_wr;

  // filter state
  logic [DELAY_BITS-1:0] low_d_r, low_d_nxt, mid_d_r, mid_d_nxt;
  logic signed [HIST_BITS-1:0] lpi_r, lpi_nxt, lpo_r, lpo_nxt;
  logic signed [HIST_BITS-1:0] mpi_r, mpi_nxt, mpo_r, mpo_nxt;
  logic bypass_r, bypass_nxt;

  // working registers
  sapa_state_t state_r, state_nxt;
  logic sec_r, sec_nxt;                          // 0 low section, 1 mid section
  logic signed [HIST_BITS-1:0] y_r, y_nxt;       // value flowing through the cascade
  logic out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic out_active_r, out_active_nxt;

  // arithmetic units
  logic mul_start, mul_busy, mul_done, mul_neg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_prod;
  logic div_start, div_busy, div_done;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic [Q_W-1:0] div_quot;

  // helpers
  logic in_acc, out_free, delays_live, byp_dec;
  logic signed [HIST_BITS-1:0] x_ext;
  logic [DELAY_BITS-1:0] d_cur;
  logic signed [HIST_BITS-1:0] x1_cur, y1_cur;
  logic cur_active;
  logic signed [MUL_A_W-1:0] num;
  logic [DIVS_W-1:0] abs_num;
  logic signed [PROD_W-1:0] sm_rnd, sec_acc;
  logic [DELAY_BITS-1:0] d_smoothed;
  logic signed [HIST_BITS-1:0] y_sec;

  sapa_mul u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b), .neg(mul_neg),
    .busy(mul_busy), .done(mul_done), .prod(mul_prod)
  );

  sapa_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dividend), .divisor(div_divisor),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  // apb register file
  assign cfg_pready = 1'b1;
  assign cfg_reg = sapa_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_reg)
      REG_LOW_TARGET: cfg_prdata = CFG_DATA_W'(low_target_r);
      REG_MID_TARGET: cfg_prdata = CFG_DATA_W'(mid_target_r);
      REG_SMOOTH:     cfg_prdata = CFG_DATA_W'(smooth_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_target_r <= '0;
      mid_target_r <= '0;
      smooth_r <= SMOOTH_BITS'(SMOOTH_RESET);
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_LOW_TARGET: low_target_r <= cfg_pwdata[DELAY_BITS-1:0];
        REG_MID_TARGET: mid_target_r <= cfg_pwdata[DELAY_BITS-1:0];
        REG_SMOOTH:     smooth_r <= cfg_pwdata[SMOOTH_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.aligner_active = out_active_r;

  // block start decision
  assign x_ext = HIST_BITS'(in_ch.sample_in);
  assign delays_live = (low_d_r >= DELAY_BITS'(IDENTITY_DELAY)) ||
                       (mid_d_r >= DELAY_BITS'(IDENTITY_DELAY));
  assign byp_dec = in_ch.block_start ? ((low_target_r == '0) && !delays_live) : bypass_r;

  // current section view
  assign d_cur = sec_r ? mid_d_r : low_d_r;
  assign x1_cur = sec_r ? mpi_r : lpi_r;
  assign y1_cur = sec_r ? mpo_r : lpo_r;
  assign cur_active = d_cur >= DELAY_BITS'(IDENTITY_DELAY);

  // coefficient c = (1 - d) / (1 + d), magnitude by division, halves rounded up
  assign num = MUL_A_W'(1 << DELAY_FRAC_BITS) - MUL_A_W'(d_cur);
  assign abs_num = num[MUL_A_W-1] ? DIVS_W'(-num) : DIVS_W'(num);
  assign div_divisor = DIVS_W'(1 << DELAY_FRAC_BITS) + DIVS_W'(d_cur);
  assign div_dividend = (DIVD_W'(abs_num) << COEF_FRAC) + DIVD_W'(div_divisor >> 1);

  // multiplier operand select: smoothing in idle/smooth, section update after divide
  always_comb begin
    case (state_r)
      ST_IDLE: begin
        mul_a = MUL_A_W'(low_target_r) - MUL_A_W'(low_d_r);
        mul_b = MUL_B_W'(smooth_r);
        mul_neg = 1'b0;
      end
      ST_SMOOTH: begin
        mul_a = MUL_A_W'(mid_target_r) - MUL_A_W'(mid_d_r);
        mul_b = MUL_B_W'(smooth_r);
        mul_neg = 1'b0;
      end
      default: begin
        // c*x - c*y1 folded into c*(x - y1)
        mul_a = MUL_A_W'(y_r) - MUL_A_W'(y1_cur);
        mul_b = div_quot;
        mul_neg = num[MUL_A_W-1];
      end
    endcase
  end

  // smoothing result: d + round(diff * smooth / 2^24)
  assign sm_rnd = mul_prod + (PROD_W'(1) <<< (SMOOTH_BITS - 1));
  assign d_smoothed = DELAY_BITS'(ROUND_W'(d_cur) + sm_rnd[PROD_W-1:SMOOTH_BITS]);

  // section output: round((c*(x - y1) + x1*2^24) / 2^24), saturated
  assign sec_acc = mul_prod + (PROD_W'(x1_cur) <<< COEF_FRAC) +
                   (PROD_W'(1) <<< (COEF_FRAC - 1));
  assign y_sec = sat_hist(sec_acc[PROD_W-1:COEF_FRAC]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = byp_dec ? ST_DONE : ST_SMOOTH;
      ST_SMOOTH: if (mul_done && sec_r) state_nxt = ST_SECT;
      ST_SECT:   state_nxt = cur_active ? ST_DIV : (sec_r ? ST_DONE : ST_SECT);
      ST_DIV:    if (div_done) state_nxt = ST_MUL;
      ST_MUL:    if (mul_done) state_nxt = sec_r ? ST_DONE : ST_SECT;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    low_d_nxt = low_d_r;
    mid_d_nxt = mid_d_r;
    lpi_nxt = lpi_r;
    lpo_nxt = lpo_r;
    mpi_nxt = mpi_r;
    mpo_nxt = mpo_r;
    bypass_nxt = bypass_r;
    sec_nxt = sec_r;
    y_nxt = y_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sample_nxt = out_sample_r;
    out_active_nxt = out_active_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          y_nxt = x_ext;
          sec_nxt = 1'b0;
          bypass_nxt = byp_dec;
          if (in_ch.block_start) begin
            if (byp_dec) begin
              low_d_nxt = '0;
              mid_d_nxt = '0;
            end else if (!delays_live) begin
              // inactive aligner: prime both histories with this sample
              lpi_nxt = x_ext;
              lpo_nxt = x_ext;
              mpi_nxt = x_ext;
              mpo_nxt = x_ext;
            end
          end
          mul_start = !byp_dec;
        end
      end
      ST_SMOOTH: begin
        if (mul_done) begin
          if (sec_r) begin
            mid_d_nxt = d_smoothed;
            sec_nxt = 1'b0;
          end else begin
            low_d_nxt = d_smoothed;
            sec_nxt = 1'b1;
            mul_start = 1'b1;
          end
        end
      end
      ST_SECT: begin
        if (cur_active) begin
          div_start = 1'b1;
        end else begin
          // identity section tracks its input
          if (sec_r) begin
            mpi_nxt = y_r;
            mpo_nxt = y_r;
          end else begin
            lpi_nxt = y_r;
            lpo_nxt = y_r;
          end
          sec_nxt = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) mul_start = 1'b1;
      end
      ST_MUL: begin
        if (mul_done) begin
          if (sec_r) begin
            mpi_nxt = y_r;
            mpo_nxt = y_sec;
          end else begin
            lpi_nxt = y_r;
            lpo_nxt = y_sec;
          end
          y_nxt = y_sec;
          sec_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sample_nxt = sat_sample(y_r);
          out_active_nxt = delays_live;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      bypass_r <= 1'b0;
      low_d_r <= '0;
      mid_d_r <= '0;
      lpi_r <= '0;
      lpo_r <= '0;
      mpi_r <= '0;
      mpo_r <= '0;
      sec_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bypass_r <= bypass_nxt;
      low_d_r <= low_d_nxt;
      mid_d_r <= mid_d_nxt;
      lpi_r <= lpi_nxt;
      lpo_r <= lpo_nxt;
      mpi_r <= mpi_nxt;
      mpo_r <= mpo_nxt;
      sec_r <= sec_nxt;
    end
    y_r <= y_nxt;
    out_sample_r <= out_sample_nxt;
    out_active_r <= out_active_nxt;
  end

  // the two serial units never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  // a bypassed request never starts the smoothing multiply
  a_bypass_no_smooth: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && byp_dec) |=> (state_r == ST_DONE) && !mul_busy)
    else $error("bypassed request entered processing");

  // divider only runs while the sequencer waits for it
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == ST_DIV))
    else $error("divider busy outside divide step");

endmodule
